// ----- rtl/rbdc_pkg.sv -----
// Shared constants, operation codes and controller/datapath interface types.
`timescale 1ns / 1ps

package rbdc_pkg;

    // Default store size and chunk limit
    localparam int DEF_BUFFER_DEPTH = 1024;
    localparam int DEF_MAX_CHUNK    = 128;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 10;
    localparam int LEN_W    = 8;
    localparam int FILL_W   = 11;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_DONE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic latch;        // capture the input word, clear the result
        logic update;       // apply push or retire
        logic chunk;        // try to start a chunk
        logic reduce;       // fold the read offset once by the store depth
        logic mem_read;     // fetch the store byte
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic offset_high;  // read offset still at or beyond the store depth
    } status_t;

endpackage

// ----- rtl/rbdc_ctrl.sv -----
// Sequencing state machine for the ring buffer chunker.
`timescale 1ns / 1ps

module rbdc_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rbdc_pkg::OP_W-1:0]  operation,
    input  rbdc_pkg::status_t          status,
    output rbdc_pkg::cmd_t             cmd,
    output logic                       busy,
    output logic                       done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_CHUNK,
        S_REDUCE,
        S_REPLY
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = (operation == rbdc_pkg::OP_READ) ? S_REDUCE : S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_CHUNK;
            end
            S_CHUNK:
            begin
                cmd.chunk  = 1'b1;
                state_next = S_REPLY;
            end
            S_REDUCE:
            begin
                // fold the offset until it lies inside the store, then fetch
                if (status.offset_high)
                begin
                    cmd.reduce = 1'b1;
                end
                else
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_REPLY;
                end
            end
            S_REPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_REPLY);

endmodule

// ----- rtl/rbdc_datapath.sv -----
// Pointers, counters, byte store and result registers of the ring buffer chunker.
`timescale 1ns / 1ps

module rbdc_datapath #(
    parameter int BUFFER_DEPTH = rbdc_pkg::DEF_BUFFER_DEPTH,
    parameter int MAX_CHUNK    = rbdc_pkg::DEF_MAX_CHUNK
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rbdc_pkg::cmd_t                 cmd,
    output rbdc_pkg::status_t              status,
    input  logic [rbdc_pkg::OP_W-1:0]      operation,
    input  logic [rbdc_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           end_of_message,
    input  logic [rbdc_pkg::OFFSET_W-1:0]  read_offset,
    output logic                           accepted,
    output logic                           chunk_valid,
    output logic [rbdc_pkg::OFFSET_W-1:0]  chunk_start,
    output logic [rbdc_pkg::LEN_W-1:0]     chunk_length,
    output logic [rbdc_pkg::BYTE_W-1:0]    read_data,
    output logic [rbdc_pkg::FILL_W-1:0]    fill_level,
    output logic                           busy_res
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int LW = $clog2(MAX_CHUNK + 1);
    localparam int MW = (CW > LW) ? CW : LW;

    // Reciprocal of the store depth, exact for every read offset
    localparam int QS    = rbdc_pkg::OFFSET_W + AW;
    localparam int RECIP = ((1 << QS) + BUFFER_DEPTH - 1) / BUFFER_DEPTH;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = rbdc_pkg::OFFSET_W + RW;

    logic [rbdc_pkg::BYTE_W-1:0] byte_store [BUFFER_DEPTH];

    // Pointer state
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] pending_reg;
    logic [CW-1:0] pending_next;
    logic [LW-1:0] inflight_reg;
    logic [LW-1:0] inflight_next;

    // Captured input word
    logic [rbdc_pkg::OP_W-1:0]     op_reg;
    logic [rbdc_pkg::OP_W-1:0]     op_next;
    logic [rbdc_pkg::BYTE_W-1:0]   data_reg;
    logic [rbdc_pkg::BYTE_W-1:0]   data_next;
    logic                          eom_reg;
    logic                          eom_next;
    logic [rbdc_pkg::OFFSET_W-1:0] offset_reg;
    logic [rbdc_pkg::OFFSET_W-1:0] offset_next;

    // Result word
    logic                          accepted_reg;
    logic                          accepted_next;
    logic                          chunk_valid_reg;
    logic                          chunk_valid_next;
    logic [rbdc_pkg::OFFSET_W-1:0] chunk_start_reg;
    logic [rbdc_pkg::OFFSET_W-1:0] chunk_start_next;
    logic [rbdc_pkg::LEN_W-1:0]    chunk_length_reg;
    logic [rbdc_pkg::LEN_W-1:0]    chunk_length_next;
    logic [rbdc_pkg::BYTE_W-1:0]   read_data_reg;

    logic          full;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail_addr;
    logic [SW-1:0] head_sum;
    logic          mem_we;
    logic          chunk_wanted;
    logic [MW-1:0] len_pending;
    logic [MW-1:0] len_capped;
    logic [MW-1:0] room;
    logic [MW-1:0] len_final;

    logic [PW-1:0]                 quot_prod;
    logic [rbdc_pkg::OFFSET_W-1:0] quot;
    logic [rbdc_pkg::OFFSET_W-1:0] offset_fold;

    assign full     = (pending_reg == CW'(BUFFER_DEPTH));
    assign tail_sum = SW'(head_reg) + SW'(pending_reg);
    assign tail_addr = (tail_sum >= SW'(BUFFER_DEPTH)) ? AW'(tail_sum - SW'(BUFFER_DEPTH))
                                                       : AW'(tail_sum);
    assign head_sum = SW'(head_reg) + SW'(inflight_reg);
    assign mem_we   = cmd.update && (op_reg == rbdc_pkg::OP_PUSH) && !full;

    assign chunk_wanted = ((op_reg == rbdc_pkg::OP_PUSH) && (eom_reg || full))
                       || (op_reg == rbdc_pkg::OP_DONE);

    // Chunk length: pending bytes, capped by the chunk limit and the end of the store
    assign len_pending = MW'(pending_reg);
    assign len_capped  = (len_pending > MW'(MAX_CHUNK)) ? MW'(MAX_CHUNK) : len_pending;
    assign room        = MW'(BUFFER_DEPTH) - MW'(head_reg);
    assign len_final   = (len_capped > room) ? room : len_capped;

    assign status.offset_high = (32'(offset_reg) >= BUFFER_DEPTH);

    // Offset modulo the store depth: quotient by reciprocal multiply, then subtract
    assign quot_prod   = PW'(offset_reg) * PW'(RECIP);
    assign quot        = rbdc_pkg::OFFSET_W'(quot_prod >> QS);
    assign offset_fold = offset_reg
                       - rbdc_pkg::OFFSET_W'(quot * rbdc_pkg::OFFSET_W'(BUFFER_DEPTH));

    always_comb
    begin
        head_next         = head_reg;
        pending_next      = pending_reg;
        inflight_next     = inflight_reg;
        op_next           = op_reg;
        data_next         = data_reg;
        eom_next          = eom_reg;
        offset_next       = offset_reg;
        accepted_next     = accepted_reg;
        chunk_valid_next  = chunk_valid_reg;
        chunk_start_next  = chunk_start_reg;
        chunk_length_next = chunk_length_reg;

        if (cmd.latch)
        begin
            op_next           = operation;
            data_next         = data_byte;
            eom_next          = end_of_message;
            offset_next       = read_offset;
            accepted_next     = 1'b0;
            chunk_valid_next  = 1'b0;
            chunk_start_next  = '0;
            chunk_length_next = '0;
        end

        if (cmd.update)
        begin
            case (op_reg)
                rbdc_pkg::OP_PUSH:
                begin
                    // drop the byte when full
                    if (!full)
                    begin
                        pending_next  = pending_reg + CW'(1);
                        accepted_next = 1'b1;
                    end
                end
                rbdc_pkg::OP_DONE:
                begin
                    // retire the chunk in flight and advance the head with wrap
                    if (inflight_reg != '0)
                    begin
                        head_next     = (head_sum >= SW'(BUFFER_DEPTH)) ? '0 : AW'(head_sum);
                        pending_next  = (pending_reg >= CW'(inflight_reg))
                                      ? pending_reg - CW'(inflight_reg) : '0;
                        inflight_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.chunk && chunk_wanted && (inflight_reg == '0) && (pending_reg != '0))
        begin
            inflight_next     = LW'(len_final);
            chunk_valid_next  = 1'b1;
            chunk_start_next  = rbdc_pkg::OFFSET_W'(head_reg);
            chunk_length_next = rbdc_pkg::LEN_W'(len_final);
        end

        if (cmd.reduce)
        begin
            offset_next = offset_fold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            pending_reg  <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            pending_reg  <= pending_next;
            inflight_reg <= inflight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        data_reg         <= data_next;
        eom_reg          <= eom_next;
        offset_reg       <= offset_next;
        accepted_reg     <= accepted_next;
        chunk_valid_reg  <= chunk_valid_next;
        chunk_start_reg  <= chunk_start_next;
        chunk_length_reg <= chunk_length_next;
    end

    // Byte store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byte_store[tail_addr] <= data_reg;
        end
        if (cmd.latch)
        begin
            read_data_reg <= '0;
        end
        else if (cmd.mem_read)
        begin
            read_data_reg <= byte_store[AW'(offset_reg)];
        end
    end

    assign accepted     = accepted_reg;
    assign chunk_valid  = chunk_valid_reg;
    assign chunk_start  = chunk_start_reg;
    assign chunk_length = chunk_length_reg;
    assign read_data    = read_data_reg;
    assign fill_level   = rbdc_pkg::FILL_W'(pending_reg);
    assign busy_res     = (inflight_reg != '0);

endmodule

// ----- rtl/ring_buffer_dma_chunker.sv -----
// Top level of the transmit ring buffer that hands out DMA chunks.
// Push, done and no-op words pass the update, chunk and reply states; done strobes in reply.
// Read words pass the reduce and reply states; a read_offset >= BUFFER_DEPTH is folded once
// by a reciprocal multiply before the single store port is read. A new word waits for done.
// Reset clears head, fill level and chunk in flight; store contents stay undefined, no clear pass.
// Results appear for one cycle on done and cannot be stalled by the receiver.
`timescale 1ns / 1ps

module ring_buffer_dma_chunker #(
    parameter int BUFFER_DEPTH = rbdc_pkg::DEF_BUFFER_DEPTH,
    parameter int MAX_CHUNK    = rbdc_pkg::DEF_MAX_CHUNK
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [rbdc_pkg::OP_W-1:0]      operation,
    input  logic [rbdc_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           end_of_message,
    input  logic [rbdc_pkg::OFFSET_W-1:0]  read_offset,
    output logic                           done,
    output logic                           accepted,
    output logic                           chunk_valid,
    output logic [rbdc_pkg::OFFSET_W-1:0]  chunk_start,
    output logic [rbdc_pkg::LEN_W-1:0]     chunk_length,
    output logic [rbdc_pkg::BYTE_W-1:0]    read_data,
    output logic [rbdc_pkg::FILL_W-1:0]    fill_level,
    output logic                           busy_res
);

    rbdc_pkg::cmd_t    cmd;
    rbdc_pkg::status_t status;

    rbdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    rbdc_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MAX_CHUNK    (MAX_CHUNK)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (operation),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .read_offset    (read_offset),
        .accepted       (accepted),
        .chunk_valid    (chunk_valid),
        .chunk_start    (chunk_start),
        .chunk_length   (chunk_length),
        .read_data      (read_data),
        .fill_level     (fill_level),
        .busy_res       (busy_res)
    );

    // a chunk in flight always has its bytes counted as pending
    a_inflight_pending: assert property (@(posedge clk) disable iff (!rst_n)
        busy_res |-> (fill_level != '0))
        else $error("chunk in flight with empty buffer");

    // a chunk reported as started is in flight
    a_chunk_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (done && chunk_valid) |-> busy_res)
        else $error("started chunk not in flight");

    // the result strobe lasts one cycle and frees the block
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not a single cycle");

    // an accepted word keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

endmodule

// ----- tb/ring_buffer_dma_chunker_tb.sv -----
// Self-checking testbench for the transmit ring buffer that hands out DMA chunks.
`timescale 1ns / 1ps

module ring_buffer_dma_chunker_tb;

    localparam int DEPTH   = rbdc_pkg::DEF_BUFFER_DEPTH;
    localparam int MAX_LEN = rbdc_pkg::DEF_MAX_CHUNK;

    // Status-only word: the block leaves its state alone
    localparam logic [rbdc_pkg::OP_W-1:0] OP_STATUS = 2'd3;

    typedef struct packed {
        logic [rbdc_pkg::OP_W-1:0]     op;
        logic [rbdc_pkg::BYTE_W-1:0]   data;
        logic                          eom;
        logic [rbdc_pkg::OFFSET_W-1:0] roff;
    } ring_word_t;

    typedef struct packed {
        logic                          accepted;
        logic                          chunk_valid;
        logic [rbdc_pkg::OFFSET_W-1:0] chunk_start;
        logic [rbdc_pkg::LEN_W-1:0]    chunk_length;
        logic [rbdc_pkg::BYTE_W-1:0]   read_data;
        logic [rbdc_pkg::FILL_W-1:0]   fill_level;
        logic                          busy_res;
    } ring_result_t;

    class ring_scoreboard;
        logic [rbdc_pkg::BYTE_W-1:0]   shadow_store [DEPTH];
        logic [rbdc_pkg::OFFSET_W-1:0] head;
        logic [rbdc_pkg::FILL_W-1:0]   pending;
        logic [rbdc_pkg::LEN_W-1:0]    inflight;
        int                            stored_total;
        int                            chunks;
        int                            refused;
        int                            wraps;
        int                            checked;
        int                            mismatches;
        ring_result_t                  expected_status [$];

        function new();
            head         = '0;
            pending      = '0;
            inflight     = '0;
            stored_total = 0;
            chunks       = 0;
            refused      = 0;
            wraps        = 0;
            checked      = 0;
            mismatches   = 0;
        endfunction

        // Hand out a chunk if none is in flight and bytes wait; never cross the store end
        function void open_chunk(inout ring_result_t r);
            int len;
            if (inflight != 0 || pending == 0)
                return;
            len = int'(pending);
            if (len > MAX_LEN)
                len = MAX_LEN;
            if (len > DEPTH - int'(head))
                len = DEPTH - int'(head);
            inflight       = rbdc_pkg::LEN_W'(len);
            r.chunk_valid  = 1'b1;
            r.chunk_start  = head;
            r.chunk_length = rbdc_pkg::LEN_W'(len);
            chunks++;
        endfunction

        function ring_result_t advance_ring(ring_word_t w);
            ring_result_t r;
            int           nxt;
            r = '0;
            case (w.op)
                rbdc_pkg::OP_PUSH:
                begin
                    if (pending < DEPTH)
                    begin
                        shadow_store[(int'(head) + int'(pending)) % DEPTH] = w.data;
                        pending++;
                        stored_total++;
                        r.accepted = 1'b1;
                    end
                    else
                        refused++;
                    if (w.eom || pending >= DEPTH)
                        open_chunk(r);
                end
                rbdc_pkg::OP_DONE:
                begin
                    if (inflight != 0)
                    begin
                        nxt = int'(head) + int'(inflight);
                        if (nxt >= DEPTH)
                        begin
                            nxt = 0;
                            wraps++;
                        end
                        head     = rbdc_pkg::OFFSET_W'(nxt);
                        pending  = (pending >= inflight) ? pending - inflight : '0;
                        inflight = '0;
                    end
                    open_chunk(r);
                end
                rbdc_pkg::OP_READ:
                    r.read_data = shadow_store[int'(w.roff) % DEPTH];
                default:
                    ;
            endcase
            r.fill_level = pending;
            r.busy_res   = (inflight != 0);
            return r;
        endfunction

        function void note_word(ring_word_t w);
            expected_status.push_back(advance_ring(w));
        endfunction

        task flag(string what, int got_v, int want_v);
            mismatches++;
            $display("%0t mismatch after %0d results: %s got %0d expected %0d",
                     $realtime, checked, what, got_v, want_v);
        endtask

        task check_status(ring_result_t got);
            ring_result_t want;
            if (expected_status.size() == 0)
            begin
                flag("result with nothing expected, fill_level", int'(got.fill_level), 0);
                return;
            end
            want = expected_status.pop_front();
            checked++;
            if (got.accepted !== want.accepted)
                flag("accepted", int'(got.accepted), int'(want.accepted));
            if (got.chunk_valid !== want.chunk_valid)
                flag("chunk_valid", int'(got.chunk_valid), int'(want.chunk_valid));
            if (got.chunk_start !== want.chunk_start)
                flag("chunk_start", int'(got.chunk_start), int'(want.chunk_start));
            if (got.chunk_length !== want.chunk_length)
                flag("chunk_length", int'(got.chunk_length), int'(want.chunk_length));
            if (got.read_data !== want.read_data)
                flag("read_data", int'(got.read_data), int'(want.read_data));
            if (got.fill_level !== want.fill_level)
                flag("fill_level", int'(got.fill_level), int'(want.fill_level));
            if (got.busy_res !== want.busy_res)
                flag("busy_res", int'(got.busy_res), int'(want.busy_res));
        endtask
    endclass

    logic                          clk;
    logic                          rst_n          = 1'b0;
    logic                          start          = 1'b0;
    logic                          busy;
    logic [rbdc_pkg::OP_W-1:0]     operation      = '0;
    logic [rbdc_pkg::BYTE_W-1:0]   data_byte      = '0;
    logic                          end_of_message = 1'b0;
    logic [rbdc_pkg::OFFSET_W-1:0] read_offset    = '0;
    logic                          done;
    logic                          accepted;
    logic                          chunk_valid;
    logic [rbdc_pkg::OFFSET_W-1:0] chunk_start;
    logic [rbdc_pkg::LEN_W-1:0]    chunk_length;
    logic [rbdc_pkg::BYTE_W-1:0]   read_data;
    logic [rbdc_pkg::FILL_W-1:0]   fill_level;
    logic                          busy_res;

    ring_scoreboard ledger;
    int             words_sent = 0;

    ring_buffer_dma_chunker #(
        .BUFFER_DEPTH (DEPTH),
        .MAX_CHUNK    (MAX_LEN)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .read_offset    (read_offset),
        .done           (done),
        .accepted       (accepted),
        .chunk_valid    (chunk_valid),
        .chunk_start    (chunk_start),
        .chunk_length   (chunk_length),
        .read_data      (read_data),
        .fill_level     (fill_level),
        .busy_res       (busy_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: the run did not drain");
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_status({accepted, chunk_valid, chunk_start, chunk_length,
                                 read_data, fill_level, busy_res});
    end

    function automatic ring_word_t mk(logic [rbdc_pkg::OP_W-1:0] op,
                                      logic [rbdc_pkg::BYTE_W-1:0] data,
                                      logic eom, logic [rbdc_pkg::OFFSET_W-1:0] roff);
        ring_word_t w;
        w.op   = op;
        w.data = data;
        w.eom  = eom;
        w.roff = roff;
        return w;
    endfunction

    function automatic ring_word_t random_word();
        return mk(rbdc_pkg::OP_W'($urandom_range(3)), rbdc_pkg::BYTE_W'($urandom_range(255)),
                  1'($urandom_range(1)), rbdc_pkg::OFFSET_W'($urandom_range(DEPTH - 1)));
    endfunction

    // Only offsets already written: the tail runs upwards from zero, so that is a prefix
    function automatic logic [rbdc_pkg::OFFSET_W-1:0] pick_offset();
        int n;
        int sel;
        n   = (ledger.stored_total < DEPTH) ? ledger.stored_total : DEPTH;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return rbdc_pkg::OFFSET_W'(n - 1);
        return rbdc_pkg::OFFSET_W'($urandom_range(n - 1));
    endfunction

    // Hold start low for a random gap, then present the word until it is taken
    task automatic send_word(ring_word_t w, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        operation      <= w.op;
        data_byte      <= w.data;
        end_of_message <= w.eom;
        read_offset    <= w.roff;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ledger.note_word(w);
        words_sent++;
    endtask

    task automatic send_message(int len, int idle_pct);
        ring_word_t w;
        for (int i = 0; i < len; i++)
        begin
            w     = random_word();
            w.op  = rbdc_pkg::OP_PUSH;
            w.eom = (i == len - 1);
            send_word(w, idle_pct);
        end
    endtask

    task automatic run_directed();
        send_word(mk(OP_STATUS, 8'h00, 1'b0, 10'd0), 0);
        send_word(mk(rbdc_pkg::OP_DONE, 8'h00, 1'b0, 10'd0), 0);
        send_word(mk(rbdc_pkg::OP_PUSH, 8'h00, 1'b0, 10'd0), 0);
        send_word(mk(rbdc_pkg::OP_PUSH, 8'hFF, 1'b1, 10'd0), 0);
        send_word(mk(rbdc_pkg::OP_PUSH, 8'hA5, 1'b1, 10'd0), 0);
        send_word(mk(rbdc_pkg::OP_READ, 8'h00, 1'b0, 10'd0), 0);
        send_word(mk(rbdc_pkg::OP_READ, 8'h00, 1'b0, 10'd1), 0);
        send_word(mk(rbdc_pkg::OP_READ, 8'hFF, 1'b1, 10'd2), 0);
        send_word(mk(rbdc_pkg::OP_DONE, 8'h00, 1'b0, 10'd0), 0);
        send_word(mk(rbdc_pkg::OP_DONE, 8'h00, 1'b0, 10'd0), 0);
        send_word(mk(rbdc_pkg::OP_DONE, 8'hFF, 1'b1, 10'h3FF), 0);
        // pending byte with nothing in flight: the next done must start it
        send_word(mk(rbdc_pkg::OP_PUSH, 8'h3C, 1'b0, 10'h3FF), 0);
        send_word(mk(rbdc_pkg::OP_DONE, 8'h00, 1'b0, 10'd0), 0);
        send_word(mk(OP_STATUS, 8'hFF, 1'b1, 10'h3FF), 0);
        send_word(mk(rbdc_pkg::OP_PUSH, 8'h55, 1'b1, 10'd0), 0);
        send_word(mk(rbdc_pkg::OP_DONE, 8'h00, 1'b0, 10'd0), 0);
        send_word(mk(rbdc_pkg::OP_READ, 8'h00, 1'b0, 10'd4), 0);
        send_word(mk(rbdc_pkg::OP_DONE, 8'h00, 1'b0, 10'd0), 0);
    endtask

    // Push without message ends until full, push into the full store, then read both store ends
    task automatic fill_store(int idle_pct);
        ring_word_t w;
        while (ledger.pending < DEPTH)
        begin
            w     = random_word();
            w.op  = rbdc_pkg::OP_PUSH;
            w.eom = 1'b0;
            send_word(w, idle_pct);
        end
        repeat (4)
        begin
            w    = random_word();
            w.op = rbdc_pkg::OP_PUSH;
            send_word(w, idle_pct);
        end
        send_word(mk(rbdc_pkg::OP_READ, 8'h00, 1'b0, '0), idle_pct);
        send_word(mk(rbdc_pkg::OP_READ, 8'hFF, 1'b1, rbdc_pkg::OFFSET_W'(DEPTH - 1)),
                  idle_pct);
    endtask

    task automatic run_phase(int target, int idle_pct, bit with_fill);
        ring_word_t w;
        int         pick;
        if (with_fill)
            fill_store(idle_pct);
        while (words_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_message(($urandom_range(9) == 0) ? $urandom_range(25, 300)
                                                      : $urandom_range(1, 24), idle_pct);
            else
            begin
                w = random_word();
                if (pick < 75)
                    w.op = rbdc_pkg::OP_DONE;
                else if (pick < 87 && ledger.stored_total > 0)
                begin
                    w.op   = rbdc_pkg::OP_READ;
                    w.roff = pick_offset();
                end
                else if (pick < 93)
                    w.op = OP_STATUS;
                else
                    w.op = rbdc_pkg::OP_PUSH;
                send_word(w, idle_pct);
            end
        end
    endtask

    initial
    begin
        int drain_cycles;
        ledger = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_phase(500, 0, 1'b0);
        run_phase(900, 71, 1'b0);
        run_phase(1850, 9, 1'b1);
        start <= 1'b0;
        drain_cycles = 0;
        while (ledger.expected_status.size() != 0 && drain_cycles < 1000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (8) @(posedge clk);
        if (ledger.expected_status.size() != 0)
            ledger.flag("results never seen, count", ledger.expected_status.size(), 0);
        $display("Sent %0d words: %0d chunks handed out, %0d pushes refused when full,",
                 words_sent, ledger.chunks, ledger.refused);
        $display("%0d head wraps; %0d results checked, %0d mismatches.",
                 ledger.wraps, ledger.checked, ledger.mismatches);
        if (ledger.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rbdc_pkg.sv
rtl/rbdc_ctrl.sv
rtl/rbdc_datapath.sv
rtl/ring_buffer_dma_chunker.sv
tb/ring_buffer_dma_chunker_tb.sv
